FILE: rtl/core/fde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_pkg
// Shared types, widths, command codes and helpers of the draw engine core.
// ----------------------------------------------------------------------------
package fde_pkg;

    // field and datapath widths
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 32;
    localparam int PIX_W     = 32;
    localparam int ADDR_W    = 40;
    localparam int STEP_W    = 24;
    localparam int IDX_W     = 26;
    localparam int FUNC_W    = 3;
    localparam int GW_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 40;

    // serial multiplier: one multiplier bit per cycle
    localparam int MUL_STEPS = DIM_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    // resolution limits
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1 << COORD_W);

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_GLYPH_START = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GLYPH_ROW   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RECT_START  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_START = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STEP        = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 2'd2;

    // rectangle phases
    localparam logic [1:0] PH_EDGES_H = 2'd0;
    localparam logic [1:0] PH_EDGES_V = 2'd1;
    localparam logic [1:0] PH_CORNER  = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_GLYPH,
        MODE_RECT,
        MODE_CLEAR
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        JOB_GLYPH,
        JOB_RECT,
        JOB_CLEAR
    } t_job;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] rect_length;
        logic [COORD_W-1:0] rect_height;
        logic [GW_W-1:0]    glyph_bytes;
        logic [PIX_W-1:0]   ink;
        logic [ROW_W-1:0]   row_bits;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  pixel_value;
        logic              last;
    } t_result;

    // resolution register clamped to 1..4096
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // glyph width clamped to 1..4 bytes
    function automatic logic [GW_W-1:0] clamp_width(input logic [GW_W-1:0] gb);
        logic [GW_W-1:0] r;
        if (gb == '0) begin
            r = GW_W'(1);
        end else if (gb > GW_W'(4)) begin
            r = GW_W'(4);
        end else begin
            r = gb;
        end
        return r;
    endfunction

    // bits of a row bitmap that lie inside the glyph width, from the top
    function automatic logic [ROW_W-1:0] glyph_mask(input logic [GW_W-1:0] w);
        logic [ROW_W-1:0] ones;
        int               nb;
        ones = '1;
        nb   = int'(w) * 8;
        if (nb > ROW_W) begin
            nb = ROW_W;
        end
        return ~(ones >> nb);
    endfunction

endpackage

FILE: rtl/core/fde_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_mul
// Serial shift-add multiplier: line * pitch + column, one multiplier bit
// per cycle, MSB first, then a final step adds the column.
// ----------------------------------------------------------------------------
module fde_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fde_pkg::DIM_W-1:0] i_mult,
    input  logic [fde_pkg::DIM_W-1:0] i_mcand,
    input  logic [fde_pkg::DIM_W-1:0] i_addend,
    output logic                      o_done,
    output logic [fde_pkg::IDX_W-1:0] o_prod
);
    import fde_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIM_W-1:0]     r_mult, n_mult;
    logic [DIM_W-1:0]     r_mcand, n_mcand;
    logic [DIM_W-1:0]     r_addend, n_addend;
    logic [IDX_W-1:0]     r_acc, n_acc;

    // one bit of the multiplier per cycle
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mult   = r_mult;
        n_mcand  = r_mcand;
        n_addend = r_addend;
        n_acc    = r_acc;
        if (i_start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_mult   = i_mult;
            n_mcand  = i_mcand;
            n_addend = i_addend;
            n_acc    = '0;
        end else if (r_busy) begin
            if (r_cnt != MUL_CNT_W'(MUL_STEPS)) begin
                n_acc  = {r_acc[IDX_W-2:0], 1'b0}
                       + (r_mult[DIM_W-1] ? IDX_W'(r_mcand) : '0);
                n_mult = {r_mult[DIM_W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
            end else begin
                n_acc  = r_acc + IDX_W'(r_addend);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mult   <= n_mult;
        r_mcand  <= n_mcand;
        r_addend <= n_addend;
        r_acc    <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/fde_outreg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_outreg
// Output holding register for pixel writes; frees when the sink takes it.
// ----------------------------------------------------------------------------
module fde_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fde_pkg::t_result  i_data,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output fde_pkg::t_result  o_data
);
    import fde_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data, n_data;

    assign o_free = !r_valid || i_ready;

    // load when free, drop when the request is taken
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_load) begin
            n_valid = 1'b1;
            n_data  = i_data;
        end else if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/framebuffer_draw_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_core
// Monochrome color-expansion drawing engine issuing 32-bit pixel writes.
// ----------------------------------------------------------------------------
// Usage
//   Command requests arrive on i_valid/o_ready with a t_request payload.
//   Pixel write requests leave on o_valid/i_ready with a t_result payload.
//   Registers (line pixels, screen lines, frame base) are written on the
//   i_cfg_valid/o_cfg_ready channel, which is always ready.
// Sequencing
//   Start commands and ignored commands issue nothing and leave the engine
//   ready. Glyph and rectangle addresses go through a serial multiplier
//   that handles one bit of the line number per cycle and then adds the
//   column; the frame base is added into the address register after it.
//   A glyph row then scans its bitmap one column per cycle up to the last
//   set bit, a set bit waiting for a free output register; an empty row
//   issues nothing. A rectangle step issues two writes, the corner one.
//   A clear step writes one zero; the multiplier forms the pixel count.
// Reset and stalls
//   Synchronous active-low reset restores the register defaults and idles
//   the engine with no write pending. A stalled sink holds the output
//   register; the engine waits and takes no new command until it is done.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fde_pkg::t_request             i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fde_pkg::t_result              o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fde_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fde_pkg::*;

    // registers
    logic [DIM_W-1:0]   r_line_pixels, n_line_pixels;
    logic [DIM_W-1:0]   r_screen_lines, n_screen_lines;
    logic [ADDR_W-1:0]  r_frame_base, n_frame_base;

    // drawing state
    t_mode              r_mode, n_mode;
    logic [COORD_W-1:0] r_org_x, n_org_x;
    logic [COORD_W-1:0] r_org_y, n_org_y;
    logic [COORD_W-1:0] r_ext_len, n_ext_len;
    logic [COORD_W-1:0] r_ext_ht, n_ext_ht;
    logic [PIX_W-1:0]   r_colour, n_colour;
    logic [GW_W-1:0]    r_width, n_width;
    logic [COORD_W-1:0] r_row_count, n_row_count;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [1:0]         r_phase, n_phase;

    // sequencer
    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ROW_W-1:0]   r_bits, n_bits;
    logic               r_last, n_last;
    logic               r_second, n_second;
    logic [DIM_W-1:0]   r_bx, n_bx;
    logic [DIM_W-1:0]   r_by, n_by;
    logic [STEP_W-1:0]  r_clr_step, n_clr_step;

    // multiplier and output register hookup
    logic               mul_start;
    logic [DIM_W-1:0]   mul_a;
    logic [DIM_W-1:0]   mul_addend;
    logic               mul_done;
    logic [IDX_W-1:0]   mul_prod;
    logic               out_load;
    t_result            out_data;
    logic               out_free;

    logic               accept;
    logic [DIM_W-1:0]   lp_eff;
    logic [DIM_W-1:0]   ls_eff;

    // rectangle step decode
    logic               len_done, ht_done;
    logic [1:0]         ph1, ph2;
    logic [STEP_W-1:0]  sc1, sc2;
    logic [DIM_W-1:0]   ox, oy, far_x, far_y, step_c;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign lp_eff      = eff_dim(r_line_pixels);
    assign ls_eff      = eff_dim(r_screen_lines);

    // skip empty rectangle phases within one step
    always_comb begin
        len_done = (r_phase == PH_EDGES_H) && (r_step >= STEP_W'(r_ext_len));
        ph1      = len_done ? PH_EDGES_V : r_phase;
        sc1      = len_done ? '0 : r_step;
        ht_done  = (ph1 == PH_EDGES_V) && (sc1 >= STEP_W'(r_ext_ht));
        ph2      = ht_done ? PH_CORNER : ph1;
        sc2      = ht_done ? '0 : sc1;
        ox       = DIM_W'(r_org_x);
        oy       = DIM_W'(r_org_y);
        far_x    = ox + DIM_W'(r_ext_len);
        far_y    = oy + DIM_W'(r_ext_ht);
        step_c   = DIM_W'(sc2[COORD_W-1:0]);
    end

    // command decode, sequencer and register writes
    always_comb begin
        n_line_pixels  = r_line_pixels;
        n_screen_lines = r_screen_lines;
        n_frame_base   = r_frame_base;
        n_mode         = r_mode;
        n_org_x        = r_org_x;
        n_org_y        = r_org_y;
        n_ext_len      = r_ext_len;
        n_ext_ht       = r_ext_ht;
        n_colour       = r_colour;
        n_width        = r_width;
        n_row_count    = r_row_count;
        n_step         = r_step;
        n_phase        = r_phase;
        n_state        = r_state;
        n_job          = r_job;
        n_addr         = r_addr;
        n_bits         = r_bits;
        n_last         = r_last;
        n_second       = r_second;
        n_bx           = r_bx;
        n_by           = r_by;
        n_clr_step     = r_clr_step;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_addend     = '0;
        out_load       = 1'b0;
        out_data       = '{write_address: r_addr, pixel_value: r_colour, last: r_last};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.func)
                        FUNC_GLYPH_START: begin
                            n_org_x     = i_req.pos_x;
                            n_org_y     = i_req.pos_y;
                            n_colour    = i_req.ink;
                            n_width     = clamp_width(i_req.glyph_bytes);
                            n_row_count = '0;
                            n_mode      = MODE_GLYPH;
                        end
                        FUNC_GLYPH_ROW: begin
                            if (r_mode == MODE_GLYPH) begin
                                n_bits      = i_req.row_bits & glyph_mask(r_width);
                                n_row_count = r_row_count + 1'b1;
                                mul_start   = 1'b1;
                                mul_a       = oy + DIM_W'(r_row_count);
                                mul_addend  = ox;
                                n_job       = JOB_GLYPH;
                                n_state     = ST_MUL;
                            end
                        end
                        FUNC_RECT_START: begin
                            n_org_x   = i_req.pos_x;
                            n_org_y   = i_req.pos_y;
                            n_ext_len = i_req.rect_length;
                            n_ext_ht  = i_req.rect_height;
                            n_colour  = i_req.ink;
                            n_phase   = PH_EDGES_H;
                            n_step    = '0;
                            n_mode    = MODE_RECT;
                        end
                        FUNC_CLEAR_START: begin
                            n_step = '0;
                            n_mode = MODE_CLEAR;
                        end
                        FUNC_STEP: begin
                            if (r_mode == MODE_RECT) begin
                                mul_start = 1'b1;
                                n_job     = JOB_RECT;
                                n_state   = ST_MUL;
                                if (ph2 == PH_EDGES_H) begin
                                    mul_a      = oy;
                                    mul_addend = ox + step_c;
                                    n_bx       = ox + step_c;
                                    n_by       = far_y;
                                    n_second   = 1'b1;
                                    n_last     = 1'b0;
                                    n_phase    = ph2;
                                    n_step     = sc2 + 1'b1;
                                end else if (ph2 == PH_EDGES_V) begin
                                    mul_a      = oy + step_c;
                                    mul_addend = ox;
                                    n_bx       = far_x;
                                    n_by       = oy + step_c;
                                    n_second   = 1'b1;
                                    n_last     = 1'b0;
                                    n_phase    = ph2;
                                    n_step     = sc2 + 1'b1;
                                end else begin
                                    // far corner closes the outline
                                    mul_a      = far_y;
                                    mul_addend = far_x;
                                    n_second   = 1'b0;
                                    n_last     = 1'b1;
                                    n_phase    = PH_EDGES_H;
                                    n_step     = '0;
                                    n_mode     = MODE_IDLE;
                                end
                            end else if (r_mode == MODE_CLEAR) begin
                                n_addr     = r_frame_base
                                           + ADDR_W'({r_step, 2'b00});
                                n_clr_step = r_step;
                                n_second   = 1'b0;
                                mul_start  = 1'b1;
                                mul_a      = ls_eff;
                                mul_addend = '0;
                                n_job      = JOB_CLEAR;
                                n_state    = ST_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MUL: begin
                if (mul_done) begin
                    if (r_job == JOB_CLEAR) begin
                        // product is the pixel count of the screen
                        n_last = (IDX_W'(r_clr_step) + 1'b1) >= mul_prod;
                        if (n_last) begin
                            n_step = '0;
                            n_mode = MODE_IDLE;
                        end else begin
                            n_step = r_clr_step + 1'b1;
                        end
                        n_state = ST_EMIT;
                    end else begin
                        n_addr  = r_frame_base + ADDR_W'({mul_prod, 2'b00});
                        n_state = (r_job == JOB_GLYPH) ? ST_SCAN : ST_EMIT;
                    end
                end
            end

            ST_SCAN: begin
                // one bitmap bit per cycle, leftmost first; a set bit waits for a free output register
                if (r_bits == '0) begin
                    n_state = ST_IDLE;
                end else if (!r_bits[ROW_W-1] || out_free) begin
                    if (r_bits[ROW_W-1]) begin
                        out_load = 1'b1;
                        out_data = '{write_address: r_addr, pixel_value: r_colour,
                                     last: (r_bits[ROW_W-2:0] == '0)};
                    end
                    n_bits = {r_bits[ROW_W-2:0], 1'b0};
                    n_addr = r_addr + ADDR_W'(4);
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{write_address: r_addr,
                                 pixel_value: (r_job == JOB_CLEAR) ? '0 : r_colour,
                                 last: r_last};
                    if (r_second) begin
                        mul_start  = 1'b1;
                        mul_a      = r_by;
                        mul_addend = r_bx;
                        n_second   = 1'b0;
                        n_state    = ST_MUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_PIXELS:  n_line_pixels  = i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_LINES: n_screen_lines = i_cfg_data[DIM_W-1:0];
                CFG_FRAME_BASE:   n_frame_base   = i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pixels  <= DIM_W'(1024);
            r_screen_lines <= DIM_W'(768);
            r_frame_base   <= '0;
            r_mode         <= MODE_IDLE;
            r_org_x        <= '0;
            r_org_y        <= '0;
            r_ext_len      <= '0;
            r_ext_ht       <= '0;
            r_colour       <= '0;
            r_width        <= GW_W'(1);
            r_row_count    <= '0;
            r_step         <= '0;
            r_phase        <= PH_EDGES_H;
            r_state        <= ST_IDLE;
            r_second       <= 1'b0;
        end else begin
            r_line_pixels  <= n_line_pixels;
            r_screen_lines <= n_screen_lines;
            r_frame_base   <= n_frame_base;
            r_mode         <= n_mode;
            r_org_x        <= n_org_x;
            r_org_y        <= n_org_y;
            r_ext_len      <= n_ext_len;
            r_ext_ht       <= n_ext_ht;
            r_colour       <= n_colour;
            r_width        <= n_width;
            r_row_count    <= n_row_count;
            r_step         <= n_step;
            r_phase        <= n_phase;
            r_state        <= n_state;
            r_second       <= n_second;
        end
        r_job      <= n_job;
        r_addr     <= n_addr;
        r_bits     <= n_bits;
        r_last     <= n_last;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_clr_step <= n_clr_step;
    end

    // line * pitch + column
    fde_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mult   (mul_a),
        .i_mcand  (lp_eff),
        .i_addend (mul_addend),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    // write request register
    fde_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_res)
    );

endmodule

FILE: rtl/core/fde_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_check
// Port-level checks of the draw engine core, bound to the top level.
// ----------------------------------------------------------------------------
module fde_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input fde_pkg::t_request             i_req,
    input logic                          o_valid,
    input logic                          i_ready,
    input fde_pkg::t_result              o_res,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [fde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [fde_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fde_pkg::*;

    // a stalled write request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("write request changed while stalled");

    // a new write only appears while a command is being worked on
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("write issued while engine idle");

    // start commands issue nothing and leave the engine ready
    a_start_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_req.func == FUNC_GLYPH_START
            || i_req.func == FUNC_RECT_START || i_req.func == FUNC_CLEAR_START)
        |=> o_ready)
        else $error("engine busy after a start command");

endmodule

bind framebuffer_draw_engine_core fde_check u_fde_check (.*);

FILE: verif/framebuffer_draw_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_core_test
// Self-checking bench for the draw engine core. Glyph, rectangle and clear
// command requests go in through a bursty driver while the write sink stalls
// on its own pattern. A cycle-accurate-free predictor tracks engine state and
// queues every pixel write it expects; the monitor compares each write
// request field by field. The run walks several resolution and base settings,
// the clamped extremes among them.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_core_test;
    import fde_pkg::*;

    typedef longint unsigned t_u64;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int MAX_SPAN      = 1 << COORD_W;

    // command codes the engine ignores
    localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_request             i_req;
    logic                 o_valid;
    logic                 i_ready;
    t_result              o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    framebuffer_draw_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pending command requests and expected pixel writes
    t_request draw_requests[$];
    t_result  pending_writes[$];

    // predicted engine state and register copies
    t_mode              eng_mode;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic [COORD_W-1:0] glyph_row;
    logic [PIX_W-1:0]   colour;
    logic [GW_W-1:0]    glyph_width;
    logic [STEP_W-1:0]  step_no;
    logic [1:0]         rect_phase;
    logic [DIM_W-1:0]   line_pixels;
    logic [DIM_W-1:0]   screen_lines;
    logic [ADDR_W-1:0]  frame_base;

    // run bookkeeping
    int          n_errors    = 0;
    int          n_accepted  = 0;
    int          n_writes    = 0;
    int          n_settings  = 0;
    int          live_queued = 0;
    int unsigned cycle_count = 0;
    bit          steady      = 1'b0;

    // sender burst and receiver stall counters
    int gap_left;
    int burst_left;
    int stall_left;

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // resolution register clamped to 1..4096
    function automatic t_u64 dim_span(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_SPAN) return MAX_SPAN;
        return v;
    endfunction

    // byte address of the pixel at column x, line y
    function automatic logic [ADDR_W-1:0] pixel_addr(input t_u64 x, input t_u64 y);
        t_u64 lin;
        lin = y * dim_span(line_pixels) + x;
        return ADDR_W'(t_u64'(frame_base) + 4 * lin);
    endfunction

    function automatic void queue_pixel_write(input logic [ADDR_W-1:0] addr,
                                              input logic [PIX_W-1:0] val,
                                              input logic fin);
        t_result w;
        w.write_address = addr;
        w.pixel_value   = val;
        w.last          = fin;
        pending_writes.push_back(w);
    endfunction

    // advance the predicted engine by one accepted command request
    function automatic void predict_draw(input t_request r);
        int unsigned span_bits;
        int unsigned last_col;
        int unsigned c;
        t_u64        total;
        logic        fin;
        case (r.func)
            FUNC_GLYPH_START: begin
                org_x       = r.pos_x;
                org_y       = r.pos_y;
                colour      = r.ink;
                glyph_width = (r.glyph_bytes == '0) ? GW_W'(1)
                            : ((r.glyph_bytes > GW_W'(4)) ? GW_W'(4) : r.glyph_bytes);
                glyph_row   = '0;
                eng_mode    = MODE_GLYPH;
            end
            FUNC_GLYPH_ROW: begin
                if (eng_mode == MODE_GLYPH) begin
                    span_bits = glyph_width * 8;
                    if (span_bits > ROW_W) span_bits = ROW_W;
                    last_col = ROW_W;
                    for (c = 0; c < span_bits; c++) begin
                        if (r.row_bits[ROW_W-1-c]) last_col = c;
                    end
                    for (c = 0; c < span_bits; c++) begin
                        if (r.row_bits[ROW_W-1-c]) begin
                            queue_pixel_write(pixel_addr(t_u64'(org_x) + c,
                                                         t_u64'(org_y) + t_u64'(glyph_row)),
                                              colour, c == last_col);
                        end
                    end
                    glyph_row = glyph_row + 1'b1;
                end
            end
            FUNC_RECT_START: begin
                org_x      = r.pos_x;
                org_y      = r.pos_y;
                span_x     = r.rect_length;
                span_y     = r.rect_height;
                colour     = r.ink;
                rect_phase = PH_EDGES_H;
                step_no    = '0;
                eng_mode   = MODE_RECT;
            end
            FUNC_CLEAR_START: begin
                step_no  = '0;
                eng_mode = MODE_CLEAR;
            end
            FUNC_STEP: begin
                case (eng_mode)
                    MODE_RECT: begin
                        // zero extents skip their edge phase within the same step
                        if (rect_phase == PH_EDGES_H && step_no >= span_x) begin
                            rect_phase = PH_EDGES_V;
                            step_no    = '0;
                        end
                        if (rect_phase == PH_EDGES_V && step_no >= span_y) begin
                            rect_phase = PH_CORNER;
                            step_no    = '0;
                        end
                        if (rect_phase == PH_EDGES_H) begin
                            queue_pixel_write(pixel_addr(t_u64'(org_x) + step_no, org_y),
                                              colour, 1'b0);
                            queue_pixel_write(pixel_addr(t_u64'(org_x) + step_no,
                                                         t_u64'(org_y) + t_u64'(span_y)),
                                              colour, 1'b0);
                            step_no = step_no + 1'b1;
                        end else if (rect_phase == PH_EDGES_V) begin
                            queue_pixel_write(pixel_addr(org_x, t_u64'(org_y) + step_no),
                                              colour, 1'b0);
                            queue_pixel_write(pixel_addr(t_u64'(org_x) + t_u64'(span_x),
                                                         t_u64'(org_y) + step_no),
                                              colour, 1'b0);
                            step_no = step_no + 1'b1;
                        end else begin
                            queue_pixel_write(pixel_addr(t_u64'(org_x) + t_u64'(span_x),
                                                         t_u64'(org_y) + t_u64'(span_y)),
                                              colour, 1'b1);
                            rect_phase = PH_EDGES_H;
                            step_no    = '0;
                            eng_mode   = MODE_IDLE;
                        end
                    end
                    MODE_CLEAR: begin
                        total = dim_span(line_pixels) * dim_span(screen_lines);
                        fin   = (t_u64'(step_no) + 1 >= total);
                        queue_pixel_write(ADDR_W'(t_u64'(frame_base) + 4 * t_u64'(step_no)),
                                          '0, fin);
                        if (fin) begin
                            step_no  = '0;
                            eng_mode = MODE_IDLE;
                        end else begin
                            step_no = step_no + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    // compare one write request against the oldest expectation
    function automatic void check_write(input t_result got);
        t_result want;
        n_writes++;
        if (pending_writes.size() == 0) begin
            $error("unexpected pixel write: address %h value %h last %b",
                   got.write_address, got.pixel_value, got.last);
            n_errors++;
        end else begin
            want = pending_writes.pop_front();
            if (got.write_address !== want.write_address) begin
                $error("write_address: expected %h, got %h",
                       want.write_address, got.write_address);
                n_errors++;
            end
            if (got.pixel_value !== want.pixel_value) begin
                $error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                n_errors++;
            end
        end
    endfunction

    // command driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_draw(i_req);
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0 && !steady) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (draw_requests.size() != 0) begin
                    i_req   <= draw_requests.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // write monitor and sink stalls: mostly short, now and then long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) check_write(o_res);
            if (steady) begin
                i_ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30)
                                                              : $urandom_range(1, 4);
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d writes still expected",
                   cycle_count, pending_writes.size());
            $display("framebuffer_draw_engine_core test failed");
            $finish;
        end
    end

    // register write on the config channel, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_PIXELS:  line_pixels  = val[DIM_W-1:0];
            CFG_SCREEN_LINES: screen_lines = val[DIM_W-1:0];
            CFG_FRAME_BASE:   frame_base   = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // wait for every request accepted and every write seen, then settle
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES) begin
            @(posedge i_clk);
            if (draw_requests.size() == 0 && !i_valid && pending_writes.size() == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
    endtask

    function automatic t_request make_cmd(input logic [FUNC_W-1:0] func,
                                          input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] l, input logic [COORD_W-1:0] h,
                                          input logic [GW_W-1:0] gb, input logic [PIX_W-1:0] ink,
                                          input logic [ROW_W-1:0] bits);
        t_request r;
        r.func        = func;
        r.pos_x       = x;
        r.pos_y       = y;
        r.rect_length = l;
        r.rect_height = h;
        r.glyph_bytes = gb;
        r.ink         = ink;
        r.row_bits    = bits;
        return r;
    endfunction

    function automatic t_request any_request();
        return make_cmd(FUNC_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                        COORD_W'($urandom), COORD_W'($urandom), GW_W'($urandom),
                        $urandom, $urandom);
    endfunction

    // bitmap mix: empty, full, sparse, random
    function automatic logic [ROW_W-1:0] glyph_bits();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_request(input t_request r);
        draw_requests.push_back(r);
        if (r.func <= FUNC_STEP) live_queued++;
    endfunction

    // step count for a sequence: complete, cut short, or overrun into idle
    function automatic int trim_steps(input int n);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, n - 1);
            1:       return n + $urandom_range(1, 2);
            default: return n;
        endcase
    endfunction

    // random part: mostly well-formed sequences, the rest noise
    task automatic queue_random(input int n_items);
        t_request r;
        int       kind;
        int       n;
        t_u64     total;
        while (live_queued < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                r      = any_request();
                r.func = FUNC_GLYPH_START;
                add_request(r);
                n = $urandom_range(1, 8);
                repeat (n) begin
                    r          = any_request();
                    r.func     = FUNC_GLYPH_ROW;
                    r.row_bits = glyph_bits();
                    add_request(r);
                end
            end else if (kind < 60) begin
                r      = any_request();
                r.func = FUNC_RECT_START;
                if ($urandom_range(0, 9) != 0) begin
                    r.rect_length = $urandom_range(0, 5);
                    r.rect_height = $urandom_range(0, 5);
                end
                add_request(r);
                if (r.rect_length <= 5 && r.rect_height <= 5) begin
                    n = trim_steps(r.rect_length + r.rect_height + 1);
                end else begin
                    n = $urandom_range(1, 4);
                end
                repeat (n) begin
                    r      = any_request();
                    r.func = FUNC_STEP;
                    add_request(r);
                end
            end else if (kind < 75) begin
                r      = any_request();
                r.func = FUNC_CLEAR_START;
                add_request(r);
                total = dim_span(line_pixels) * dim_span(screen_lines);
                n = (total <= 48) ? trim_steps(int'(total)) : $urandom_range(1, 5);
                repeat (n) begin
                    r      = any_request();
                    r.func = FUNC_STEP;
                    add_request(r);
                end
            end else begin
                add_request(any_request());
            end
        end
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] lp, input logic [DIM_W-1:0] sl,
                             input logic [ADDR_W-1:0] base, input bit calm, input int n_items);
        write_reg(CFG_LINE_PIXELS, CFG_DAT_W'(lp));
        write_reg(CFG_SCREEN_LINES, CFG_DAT_W'(sl));
        write_reg(CFG_FRAME_BASE, CFG_DAT_W'(base));
        steady      = calm;
        live_queued = 0;
        queue_random(n_items);
        wait_idle();
        n_settings++;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LINE_PIXELS;
        i_cfg_data  = '0;

        // predictor state after reset
        eng_mode     = MODE_IDLE;
        org_x        = '0;
        org_y        = '0;
        span_x       = '0;
        span_y       = '0;
        glyph_row    = '0;
        colour       = '0;
        glyph_width  = 1;
        step_no      = '0;
        rect_phase   = PH_EDGES_H;
        line_pixels  = 1024;
        screen_lines = 768;
        frame_base   = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wrong-state commands and ignored codes
        add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_request(make_cmd(FUNC_RSVD_5, 0, 0, 0, 0, 0, 0, 0));
        add_request(make_cmd(FUNC_RSVD_7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 3'd7,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // glyph width zero taken as one byte, origin at the far corner
        add_request(make_cmd(FUNC_GLYPH_START, 12'hFFF, 12'hFFF, 0, 0, 3'd0,
                             32'hFFFF_FFFF, 0));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // three bytes: 24 pixels, bit 0 lies outside
        add_request(make_cmd(FUNC_GLYPH_START, 0, 0, 0, 0, 3'd3, 32'h0, 0));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'h8000_0001));
        // width above four bytes clamps to four
        add_request(make_cmd(FUNC_GLYPH_START, 100, 200, 0, 0, 3'd7, 32'hA5A5_5A5A, 0));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'h0000_0001));
        add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        // empty rectangle: straight to the corner
        add_request(make_cmd(FUNC_RECT_START, 12'hFFF, 12'hFFF, 0, 0, 0, 32'h1234_5678, 0));
        add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        // zero height skips the vertical edges
        add_request(make_cmd(FUNC_RECT_START, 10, 20, 2, 0, 0, 32'h00FF_00FF, 0));
        repeat (3) add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        // zero length skips the horizontal edges
        add_request(make_cmd(FUNC_RECT_START, 0, 0, 0, 1, 0, 32'hDEAD_BEEF, 0));
        repeat (2) add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        // largest rectangle abandoned by a clear, which is left unfinished
        add_request(make_cmd(FUNC_RECT_START, 5, 6, 12'hFFF, 12'hFFF, 0, 32'hFFFF_FFFF, 0));
        add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        add_request(make_cmd(FUNC_GLYPH_ROW, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_request(make_cmd(FUNC_CLEAR_START, 0, 0, 0, 0, 0, 0, 0));
        repeat (2) add_request(make_cmd(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();
        n_settings++;

        // random phases over register settings, clamped extremes included
        run_phase(0, 0, 40'hFF_FFFF_FFFF, 1'b0, 70);
        run_phase(13'd8191, 1, 0, 1'b0, 60);
        run_phase(13'd4096, 13'd4096, ADDR_W'({$urandom, $urandom}), 1'b0, 60);
        run_phase($urandom_range(1, 40), $urandom_range(1, 8),
                  ADDR_W'({$urandom, $urandom}), 1'b1, 60);
        run_phase(5, 3, 40'hFF_FFFF_FF00, 1'b0, 70);
        run_phase(1, 13'd8191, ADDR_W'({$urandom, $urandom}), 1'b0, 60);
        run_phase(13'd4095, 13'd4097, ADDR_W'({$urandom, $urandom}), 1'b0, 20);

        $display("covered %0d command requests and %0d pixel writes over %0d register settings",
                 n_accepted, n_writes, n_settings);
        if (n_errors == 0) begin
            $display("framebuffer_draw_engine_core test passed");
        end else begin
            $display("framebuffer_draw_engine_core test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fde_pkg.sv
rtl/core/fde_mul.sv
rtl/core/fde_outreg.sv
rtl/core/framebuffer_draw_engine_core.sv
rtl/core/fde_check.sv
verif/framebuffer_draw_engine_core_test.sv
